// ----- rtl/wsd_pkg.sv -----
package wsd_pkg;

	// Frame opcodes that the parser acts on.
	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [3:0] OPC_CLOSE = 4'h8;
	localparam logic [3:0] OPC_PING  = 4'h9;

	// Seven-bit length codes that announce an extended length field.
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Number of header bytes that follow for each extension.
	localparam logic [3:0] HDR_CNT_EXT16 = 4'd2;
	localparam logic [3:0] HDR_CNT_EXT64 = 4'd8;
	localparam logic [3:0] HDR_CNT_MASK  = 4'd4;

	// First bytes of the control replies; the second byte is always zero.
	localparam logic [7:0] REPLY_PONG  = 8'h8A;
	localparam logic [7:0] REPLY_CLOSE = 8'h88;
	localparam logic [7:0] REPLY_TAIL  = 8'h00;

	// Kind of an output beat.
	localparam logic KIND_TEXT  = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	// Result queue geometry.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_SKIP    = 3'd5
	} wsd_phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_kind;
		logic       last;
	} wsd_beat_t;

	// Up to two result beats produced by one accepted input byte.
	typedef struct packed {
		logic [1:0] count;
		wsd_beat_t  first;
		wsd_beat_t  second;
	} wsd_push_t;

	typedef struct packed {
		wsd_phase_t phase;
	} wsd_status_t;

endpackage

// ----- rtl/wsd_channels.sv -----
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_buffer;

	modport source (output valid, output rx_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface wsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_kind;
	logic       last;

	modport source (output valid, output out_byte, output out_kind, output last, input ready);
	modport sink   (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

// ----- rtl/wsd_parser.sv -----
module wsd_parser
	import wsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_buffer,
	output wsd_push_t   push,
	output wsd_status_t status
);

	wsd_phase_t  phase_q, phase_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [63:0] pidx_q, pidx_d;

	logic        hdr_done;
	logic        len_done;
	logic [7:0]  key_byte;
	logic        fin;
	wsd_push_t   res;

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		len_d     = len_q;
		key_d     = key_q;
		pidx_d    = pidx_q;
		hdr_done  = 1'b0;
		len_done  = 1'b0;
		fin       = 1'b0;
		res       = '0;

		case (pidx_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase

		case (phase_q)
			PH_HDR0: begin
				opcode_d = rx_byte[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				mask_d = rx_byte[7];
				len_d  = '0;
				if (rx_byte[6:0] == LEN_EXT16) begin
					hdr_cnt_d = HDR_CNT_EXT16;
					phase_d   = PH_EXTLEN;
				end else if (rx_byte[6:0] == LEN_EXT64) begin
					hdr_cnt_d = HDR_CNT_EXT64;
					phase_d   = PH_EXTLEN;
				end else begin
					len_d    = {57'd0, rx_byte[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d     = {len_q[55:0], rx_byte};
				hdr_cnt_d = hdr_cnt_q - 4'd1;
				len_done  = (hdr_cnt_d == 4'd0);
			end
			PH_MASK: begin
				key_d     = {key_q[23:0], rx_byte};
				hdr_cnt_d = hdr_cnt_q - 4'd1;
				hdr_done  = (hdr_cnt_d == 4'd0);
			end
			PH_PAYLOAD: begin
				pidx_d = pidx_q + 64'd1;
				fin    = (pidx_d == len_q);
				if (opcode_q == OPC_TEXT) begin
					res.count           = 2'd1;
					res.first.out_byte  = rx_byte ^ (mask_q ? key_byte : 8'h00);
					res.first.out_kind  = KIND_TEXT;
					res.first.last      = fin | end_of_buffer;
				end
				if (fin) begin
					phase_d = PH_SKIP;
				end
			end
			default: begin
			end
		endcase

		// Length known: either the mask key follows or the header is complete.
		if (len_done) begin
			if (mask_d) begin
				hdr_cnt_d = HDR_CNT_MASK;
				key_d     = '0;
				phase_d   = PH_MASK;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			if (opcode_q == OPC_PING || opcode_q == OPC_CLOSE) begin
				res.count           = 2'd2;
				res.first.out_byte  = (opcode_q == OPC_PING) ? REPLY_PONG : REPLY_CLOSE;
				res.first.out_kind  = KIND_REPLY;
				res.first.last      = 1'b0;
				res.second.out_byte = REPLY_TAIL;
				res.second.out_kind = KIND_REPLY;
				res.second.last     = 1'b1;
			end
			pidx_d  = '0;
			phase_d = (len_d != 64'd0) ? PH_PAYLOAD : PH_SKIP;
		end

		if (end_of_buffer) begin
			phase_d   = PH_HDR0;
			hdr_cnt_d = '0;
			opcode_d  = '0;
			mask_d    = 1'b0;
			len_d     = '0;
			key_d     = '0;
			pidx_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			hdr_cnt_q <= '0;
			opcode_q  <= '0;
			mask_q    <= 1'b0;
			len_q     <= '0;
			key_q     <= '0;
			pidx_q    <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			opcode_q  <= opcode_d;
			mask_q    <= mask_d;
			len_q     <= len_d;
			key_q     <= key_d;
			pidx_q    <= pidx_d;
		end
	end

	always_comb begin
		push       = res;
		push.count = accept ? res.count : 2'd0;
		status     = '{phase: phase_q};
	end

endmodule

// ----- rtl/wsd_result_queue.sv -----
module wsd_result_queue
	import wsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  wsd_push_t push,
	input  logic      pop,
	output wsd_beat_t head,
	output logic      head_valid,
	output logic      has_room
);

	wsd_beat_t          mem_q [QDEPTH];
	logic [QAW-1:0]     wptr_q, rptr_q;
	logic [QAW:0]       count_q;
	logic               do_pop;
	logic [QAW-1:0]     wptr_next;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rptr_q];
	assign has_room   = (count_q <= (QAW+1)'(QDEPTH - 2));
	assign do_pop     = pop & head_valid;
	assign wptr_next  = wptr_q + QAW'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wptr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + QAW'(push.count);
			rptr_q  <= rptr_q + QAW'(do_pop);
			count_q <= count_q + (QAW+1)'(push.count) - (QAW+1)'(do_pop);
		end
	end

endmodule

// ----- rtl/websocket_frame_deframer_core.sv -----
// Channel  Direction  Beat payload                      Handshake
// in_ch    sink       rx_byte[7:0], end_of_buffer       valid / ready
// out_ch   source     out_byte[7:0], out_kind, last     valid / ready
//
// One received byte is taken per clock while the result queue has room for
// two beats; its results are registered in the queue and reach out_ch in the cycle after acceptance at the earliest.
// A ping or close header yields two reply beats; out_ch runs at one beat per
// clock while its receiver is ready, and in_ch pauses only while the four-entry result queue holds three or
// four beats.
// Reset (arst_n low) returns the parser to the first header byte and empties
// the queue; no clearing pass is needed. A stall on out_ch holds the head beat.
module websocket_frame_deframer_core
	import wsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	wsd_in_if.sink    in_ch,
	wsd_out_if.source out_ch
);

	// Parser state is updated straight from the accepted byte; the result
	// beats it produces are written into the queue, which acts as the
	// output register and decouples the two channels.
	logic        accept;
	logic        has_room;
	logic        head_valid;
	wsd_push_t   push;
	wsd_status_t status;
	wsd_beat_t   head;

	assign in_ch.ready = has_room;
	assign accept      = in_ch.valid & has_room;

	wsd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_byte       (in_ch.rx_byte),
		.end_of_buffer (in_ch.end_of_buffer),
		.push          (push),
		.status        (status)
	);

	wsd_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (out_ch.ready),
		.head       (head),
		.head_valid (head_valid),
		.has_room   (has_room)
	);

	// The head of the queue drives the output channel directly.
	assign out_ch.valid    = head_valid;
	assign out_ch.out_byte = head.out_byte;
	assign out_ch.out_kind = head.out_kind;
	assign out_ch.last     = head.last;

	// The end of a buffer always brings the parser back to the header start.
	a_eob_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.end_of_buffer |=> status.phase == PH_HDR0)
		else $error("parser not at header start after end of buffer");

	// A two-beat push is always a control reply closed by its last beat.
	a_reply_pair: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.first.out_kind == KIND_REPLY &&
			!push.first.last && push.second.out_kind == KIND_REPLY && push.second.last)
		else $error("malformed control reply pair");

	// Results only come from accepted bytes, and never while the queue is full.
	a_push_gated: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> accept && has_room)
		else $error("result pushed without an accepted byte");

	// Text beats are produced only in the payload phase.
	a_text_phase: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd1 |-> status.phase == PH_PAYLOAD)
		else $error("text beat outside payload phase");

endmodule

// ----- bench/websocket_frame_deframer_core_tb.sv -----
`timescale 1ns / 1ps

module websocket_frame_deframer_core_tb;
	import wsd_pkg::*;

	// Run limits. The slowest correct run is about 1800 bytes, each one
	// waiting out its longest idle gap and causing two beats that each wait out the
	// longest stall, plus the long hold-offs. The limit is several times that.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned RANDOM_BYTES = 1700;

	// The output side stops taking beats for a long stretch once per period.
	localparam int unsigned HOLD_PERIOD = 2500;
	localparam int unsigned HOLD_START  = 1200;
	localparam int unsigned HOLD_CYCLES = 300;

	// An opcode that the parser consumes without any output.
	localparam logic [3:0] OPC_BINARY = 4'h2;

	// How the payload length is written on the wire.
	typedef enum int {
		LEN_FORM_7,
		LEN_FORM_16,
		LEN_FORM_64
	} len_form_t;

	// One received byte waiting to be offered, with its idle gap in front.
	typedef struct {
		logic [7:0]  data;
		logic        eob;
		int unsigned gap;
	} rx_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wsd_in_if  in_ch();
	wsd_out_if out_ch();

	websocket_frame_deframer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #4 clk = ~clk;

	// Bookkeeping shared by the processes below.
	rx_item_t    rx_pending[$];
	rx_item_t    rx_cur;
	bit          rx_loaded = 1'b0;
	int unsigned rx_wait = 0;
	wsd_beat_t   expected_beats[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned buffers_built = 0;
	int unsigned bytes_built = 0;
	int unsigned bytes_accepted = 0;
	int unsigned text_beats = 0;
	int unsigned reply_beats = 0;
	int unsigned in_stall_cycles = 0;

	// Parser state that the prediction keeps for itself.
	wsd_phase_t  parse_phase;
	logic [3:0]  hdr_left;
	logic [3:0]  frame_opc;
	logic        frame_masked;
	logic [63:0] frame_len;
	logic [31:0] frame_key;
	logic [63:0] pay_idx;

	task automatic reset_parser();
		parse_phase  = PH_HDR0;
		hdr_left     = '0;
		frame_opc    = '0;
		frame_masked = 1'b0;
		frame_len    = '0;
		frame_key    = '0;
		pay_idx      = '0;
	endtask

	// The header is complete: ping and close answer at once with two reply
	// beats, and a frame without payload goes straight to skipping.
	task automatic finish_header();
		if (frame_opc == OPC_PING) begin
			expected_beats.push_back(wsd_beat_t'{REPLY_PONG, KIND_REPLY, 1'b0});
			expected_beats.push_back(wsd_beat_t'{REPLY_TAIL, KIND_REPLY, 1'b1});
		end else if (frame_opc == OPC_CLOSE) begin
			expected_beats.push_back(wsd_beat_t'{REPLY_CLOSE, KIND_REPLY, 1'b0});
			expected_beats.push_back(wsd_beat_t'{REPLY_TAIL, KIND_REPLY, 1'b1});
		end
		pay_idx = '0;
		parse_phase = (frame_len != 0) ? PH_PAYLOAD : PH_SKIP;
	endtask

	// The length is known: a masked frame still has four key bytes to come.
	task automatic length_known();
		if (frame_masked) begin
			hdr_left = HDR_CNT_MASK;
			frame_key = '0;
			parse_phase = PH_MASK;
		end else begin
			finish_header();
		end
	endtask

	// Advances the parser by one received byte and queues the beats it causes.
	task automatic deframe_byte(input logic [7:0] b, input logic eob);
		logic [7:0] v;
		logic       fin;
		case (parse_phase)
		PH_HDR0: begin
			frame_opc = b[3:0];
			parse_phase = PH_HDR1;
		end
		PH_HDR1: begin
			frame_masked = b[7];
			frame_len = '0;
			if (b[6:0] == LEN_EXT16) begin
				hdr_left = HDR_CNT_EXT16;
				parse_phase = PH_EXTLEN;
			end else if (b[6:0] == LEN_EXT64) begin
				hdr_left = HDR_CNT_EXT64;
				parse_phase = PH_EXTLEN;
			end else begin
				frame_len = 64'(b[6:0]);
				length_known();
			end
		end
		PH_EXTLEN: begin
			frame_len = {frame_len[55:0], b};
			hdr_left = hdr_left - 4'd1;
			if (hdr_left == 0)
				length_known();
		end
		PH_MASK: begin
			frame_key = {frame_key[23:0], b};
			hdr_left = hdr_left - 4'd1;
			if (hdr_left == 0)
				finish_header();
		end
		PH_PAYLOAD: begin
			v = b;
			// Key bytes are applied in wire order, the first one at index 0.
			if (frame_masked)
				v = v ^ frame_key[(3 - pay_idx[1:0]) * 8 +: 8];
			pay_idx = pay_idx + 64'd1;
			fin = (pay_idx == frame_len);
			if (frame_opc == OPC_TEXT)
				expected_beats.push_back(wsd_beat_t'{v, KIND_TEXT, fin | eob});
			if (fin)
				parse_phase = PH_SKIP;
		end
		default: begin
		end
		endcase
		if (eob)
			reset_parser();
	endtask

	function automatic int unsigned idle_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// Builds one receive buffer holding a single frame. The frame carries
	// `body` payload bytes and `extra` trailing bytes; a nonzero `cut`
	// truncates the buffer to that many bytes. The last byte ends the buffer.
	task automatic push_buffer(input logic [3:0] opc, input logic masked,
			input len_form_t form, input logic [63:0] len, input int body,
			input int extra, input int cut);
		logic [7:0]  frame_q[$];
		logic [31:0] key;
		logic [7:0]  r;
		bit          calm;
		int          i;
		key = $urandom();
		r = $urandom();
		calm = ($urandom_range(0, 3) == 0);
		// The upper nibble holds FIN and the reserved bits, which the
		// parser does not look at, so they are random.
		frame_q.push_back({r[7:4], opc});
		case (form)
		LEN_FORM_16: begin
			frame_q.push_back({masked, LEN_EXT16});
			frame_q.push_back(len[15:8]);
			frame_q.push_back(len[7:0]);
		end
		LEN_FORM_64: begin
			frame_q.push_back({masked, LEN_EXT64});
			for (i = 7; i >= 0; i--)
				frame_q.push_back(len[i * 8 +: 8]);
		end
		default: begin
			frame_q.push_back({masked, len[6:0]});
		end
		endcase
		if (masked)
			for (i = 3; i >= 0; i--)
				frame_q.push_back(key[i * 8 +: 8]);
		for (i = 0; i < body + extra; i++) begin
			r = $urandom();
			frame_q.push_back(r);
		end
		if (cut > 0)
			while (frame_q.size() > cut)
				void'(frame_q.pop_back());
		foreach (frame_q[k])
			rx_pending.push_back('{data: frame_q[k], eob: (k == frame_q.size() - 1),
				gap: idle_gap(calm)});
		bytes_built += frame_q.size();
		buffers_built++;
	endtask

	// Mostly short lengths, so that frames finish and their ends get
	// exercised; a few longer ones in the 7-bit and 16-bit length forms.
	task automatic pick_length(output len_form_t form, output logic [63:0] len);
		int unsigned f;
		f = $urandom_range(0, 19);
		if (f < 12) begin
			form = LEN_FORM_7;
			len = $urandom_range(0, 20);
		end else if (f < 14) begin
			form = LEN_FORM_7;
			len = $urandom_range(21, 125);
		end else if (f < 17) begin
			form = LEN_FORM_16;
			len = $urandom_range(0, 40);
		end else if (f < 18) begin
			form = LEN_FORM_16;
			len = $urandom_range(126, 300);
		end else begin
			form = LEN_FORM_64;
			len = $urandom_range(0, 24);
		end
	endtask

	// Driver. The bytes go out in order from rx_pending; each one first
	// waits out its own idle gap with valid low, then stays offered until the
	// block takes it. The prediction runs on the beat at the edge where it is
	// accepted, so the expected beats are queued in the order the block sees
	// the bytes.
	always @(posedge clk) begin
		logic offer;
		if (arst_n) begin
			offer = in_ch.valid;
			if (in_ch.valid && !in_ch.ready)
				in_stall_cycles++;
			if (in_ch.valid && in_ch.ready) begin
				deframe_byte(in_ch.rx_byte, in_ch.end_of_buffer);
				bytes_accepted++;
				offer = 1'b0;
				rx_loaded = 1'b0;
			end
			if (!offer) begin
				if (!rx_loaded && rx_pending.size() > 0) begin
					rx_cur = rx_pending.pop_front();
					rx_wait = rx_cur.gap;
					rx_loaded = 1'b1;
				end
				if (rx_loaded) begin
					if (rx_wait == 0)
						offer = 1'b1;
					else
						rx_wait--;
				end
			end
			// Valid gets exactly one assignment per edge, so a byte that
			// follows right behind the previous one keeps valid high.
			in_ch.valid <= offer;
			if (offer) begin
				in_ch.rx_byte <= rx_cur.data;
				in_ch.end_of_buffer <= rx_cur.eob;
			end
		end
	end

	// Long hold-off of the output side, timed by its own cycle count. The
	// sender keeps offering bytes meanwhile, so the result queue fills up and
	// the block has to push back on its input.
	int unsigned hold_clock = 0;
	int unsigned hold_left = 0;
	logic        tx_hold = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			hold_clock <= hold_clock + 1;
			if (hold_clock % HOLD_PERIOD == HOLD_START)
				hold_left <= HOLD_CYCLES;
			else if (hold_left > 0)
				hold_left <= hold_left - 1;
			tx_hold <= (hold_left != 0);
		end
	end

	// Monitor. Every beat taken from out_ch is checked field by field against
	// the oldest expected beat. After each beat the receiver draws a random
	// stall, except in every fourth window of the run, where it
	// takes beats back to back.
	int unsigned tx_stall = 0;

	always @(posedge clk) begin
		wsd_beat_t want;
		bit        calm;
		if (arst_n) begin
			calm = ((cycle_count / 1500) % 4) == 1;
			if (out_ch.valid && out_ch.ready) begin
				if (out_ch.out_kind == KIND_REPLY)
					reply_beats++;
				else
					text_beats++;
				if (expected_beats.size() == 0) begin
					$error("unexpected beat: out_byte %0h out_kind %0b last %0b",
						out_ch.out_byte, out_ch.out_kind, out_ch.last);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (out_ch.out_byte !== want.out_byte) begin
						$error("out_byte expected %0h actual %0h",
							want.out_byte, out_ch.out_byte);
						fail_count++;
					end
					if (out_ch.out_kind !== want.out_kind) begin
						$error("out_kind expected %0b actual %0b",
							want.out_kind, out_ch.out_kind);
						fail_count++;
					end
					if (out_ch.last !== want.last) begin
						$error("last expected %0b actual %0b", want.last, out_ch.last);
						fail_count++;
					end
				end
				tx_stall = idle_gap(calm);
			end else if (tx_stall > 0) begin
				tx_stall--;
			end
			out_ch.ready <= !tx_hold && (tx_stall == 0);
		end
	end

	// Watchdog: a run that does not finish in time has lost or stuck beats.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("websocket_frame_deframer_core_tb failed");
			$finish;
		end
	end

	initial begin
		len_form_t   form;
		logic [63:0] len;
		logic [3:0]  opc;
		logic [7:0]  r;
		int unsigned pick;
		int unsigned hdr_bytes;
		int unsigned n;
		bit          calm;
		logic        masked;

		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		in_ch.end_of_buffer = 1'b0;
		out_ch.ready = 1'b0;
		reset_parser();

		// Directed buffers. A bare ping with no payload, an unmasked close
		// with no payload, a masked text frame followed by a stray byte, a
		// buffer that ends on its first header byte, a silent binary frame
		// with a 16-bit length, and a text frame with a 64-bit length whose
		// top bit is set, cut off on its first payload byte.
		push_buffer(OPC_PING, 1'b0, LEN_FORM_7, 64'd0, 0, 0, 0);
		push_buffer(OPC_CLOSE, 1'b0, LEN_FORM_7, 64'd0, 0, 0, 0);
		push_buffer(OPC_TEXT, 1'b1, LEN_FORM_7, 64'd2, 2, 1, 0);
		push_buffer(OPC_TEXT, 1'b0, LEN_FORM_7, 64'd5, 0, 0, 1);
		push_buffer(OPC_BINARY, 1'b0, LEN_FORM_16, 64'd1, 1, 0, 0);
		push_buffer(OPC_TEXT, 1'b0, LEN_FORM_64, 64'h8000_0000_0000_0002, 1, 0, 0);

		// Random buffers. Most are well-formed frames with random content;
		// the rest are truncated headers, truncated payloads and noise.
		while (bytes_built < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			masked = $urandom_range(0, 1);
			pick_length(form, len);
			if (pick < 50) begin
				push_buffer(OPC_TEXT, masked, form, len, int'(len),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 0);
			end else if (pick < 58) begin
				// The buffer ends inside the payload; sometimes the length is
				// a full random 64-bit value.
				if ($urandom_range(0, 1) == 1) begin
					form = LEN_FORM_64;
					len = {$urandom(), $urandom()};
					push_buffer(OPC_TEXT, masked, form, len, $urandom_range(0, 6), 0, 0);
				end else begin
					len = len + 64'd1;
					push_buffer(OPC_TEXT, masked, form, len,
						$urandom_range(0, int'(len) - 1), 0, 0);
				end
			end else if (pick < 72) begin
				opc = ($urandom_range(0, 1) == 1) ? OPC_PING : OPC_CLOSE;
				push_buffer(opc, masked, form, len, int'(len),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 0);
			end else if (pick < 80) begin
				do
					opc = $urandom_range(0, 15);
				while (opc == OPC_TEXT || opc == OPC_PING || opc == OPC_CLOSE);
				push_buffer(opc, masked, form, len, int'(len), 0, 0);
			end else if (pick < 90) begin
				// The buffer ends before the header is complete.
				hdr_bytes = 2 + (masked ? 4 : 0) + (form == LEN_FORM_16 ? 2 : 0)
					+ (form == LEN_FORM_64 ? 8 : 0);
				opc = ($urandom_range(0, 1) == 1) ? OPC_PING : OPC_TEXT;
				push_buffer(opc, masked, form, len, 0, 0, $urandom_range(1, hdr_bytes - 1));
			end else begin
				n = $urandom_range(1, 8);
				calm = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < n; i++) begin
					r = $urandom();
					rx_pending.push_back('{data: r, eob: (i == n - 1), gap: idle_gap(calm)});
				end
				bytes_built += n;
				buffers_built++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the sender to run dry, then for every expected beat, then
		// give the block a few more cycles to show any beat it should not send.
		while (rx_pending.size() != 0 || rx_loaded || in_ch.valid)
			@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d buffers, %0d bytes; checked %0d text beats and %0d reply beats.",
			buffers_built, bytes_accepted, text_beats, reply_beats);
		$display("The input was held back for %0d cycles by a full result queue.",
			in_stall_cycles);
		if (fail_count == 0)
			$display("websocket_frame_deframer_core_tb passed");
		else
			$display("websocket_frame_deframer_core_tb failed");
		$finish;
	end

endmodule
